>>> rtl/core/bpl_pkg.sv
// bpl_pkg: shared types and constants of the bitmap to position list decoder
// used by bpl_lead, bpl_out and bitmap_to_position_list; depends on nothing
`timescale 1ns / 1ps

package bpl_pkg;

    // word counter width and its limit
    localparam int CNT_W = 28;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // position and register port widths
    localparam int POS_W = 32;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_POS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_POS   = 2'd1;

    // one emitted result
    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             last_in_word;
        logic             range_done;
    } result_t;

    // status of the leading-one search
    typedef struct packed {
        logic any;   // at least one bit set
        logic last;  // the found bit is the only one set
    } lead_stat_t;

endpackage

>>> rtl/core/bpl_lead.sv
// bpl_lead: shared leading-one unit, finds the lowest-offset set bit of a word
// depends on bpl_pkg
`timescale 1ns / 1ps

module bpl_lead #(
    parameter int WORD_BITS = 32
) (
    input  logic [WORD_BITS-1:0]         word,
    output logic [$clog2(WORD_BITS)-1:0] offset,
    output logic [WORD_BITS-1:0]         rest,
    output bpl_pkg::lead_stat_t          stat
);
    import bpl_pkg::*;

    localparam int OFF_W = $clog2(WORD_BITS);

    logic [OFF_W-1:0] lead_bit;

    // highest set bit wins, that is the lowest offset
    always_comb
    begin
        lead_bit = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (word[b])
            begin
                lead_bit = OFF_W'(b);
            end
        end
    end

    // offset from the top, word with that bit cleared
    always_comb
    begin
        offset = OFF_W'(WORD_BITS - 1) - lead_bit;
        rest   = word;
        rest[lead_bit] = 1'b0;
        stat.any  = |word;
        stat.last = (rest == '0);
    end

endmodule

>>> rtl/core/bpl_out.sv
// bpl_out: output register that holds one result until the receiver takes it
// depends on bpl_pkg
`timescale 1ns / 1ps

module bpl_out (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  bpl_pkg::result_t result,
    output logic             space,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [31:0]      position,
    output logic             last_in_word,
    output logic             range_done
);
    import bpl_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // room for a new result when empty or when the held one leaves now
    assign space = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid    = valid_reg;
    assign position     = data_reg.position;
    assign last_in_word = data_reg.last_in_word;
    assign range_done   = data_reg.range_done;

endmodule

>>> rtl/core/bitmap_to_position_list.sv
// bitmap_to_position_list: top level, sequencer, word counter and registers
// depends on bpl_pkg, bpl_lead and bpl_out
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall) carries one bitmap word per transaction
//   plus first_word, which restarts the word counter with that word. Output
//   channel (out_valid / out_stall) carries one position per transaction, in
//   order of rising offset, with last_in_word and range_done marks.
//   Configuration port (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
//   start_pos (index 0) and end_pos (index 1); cfg_ready is always high.
// Timing:
//   a word is taken in idle, then passes a range check state and a masking
//   state, then the leading-one unit finds one set bit per cycle while the
//   output has room; in_stall stays high meanwhile. Words past the range
//   are dropped without leaving idle. The first position of a word passes
//   the check, mask and scan states and then the output register.
// Stall: a stalled output holds its result and the scan waits for room.
// Reset: clears the counter, the finished flag and both registers to zero.

module bitmap_to_position_list #(
    parameter int WORD_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [31:0]                        bitmap_word,
    input  logic                               first_word,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [31:0]                        position,
    output logic                               last_in_word,
    output logic                               range_done,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bpl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                        cfg_data
);
    import bpl_pkg::*;

    localparam int OFF_W  = $clog2(WORD_BITS);
    localparam int BASE_W = CNT_W + 1 + $clog2(WORD_BITS);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_MASK  = 2'd2;
    localparam logic [1:0] ST_SCAN  = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [BASE_W-1:0]    base_reg, base_next;
    logic                 finished_reg, finished_next;
    logic                 final_reg, final_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [OFF_W-1:0]     diff_reg;
    logic                 past_reg;
    logic [POS_W-1:0]     wpos_reg;
    logic [POS_W-1:0]     start_pos_reg;
    logic [POS_W-1:0]     end_pos_reg;
    logic [POS_W-1:0]     span_reg;

    logic                 in_take;
    logic [BASE_W-1:0]    span_ext;
    logic [BASE_W-1:0]    base_top;
    logic [WORD_BITS-1:0] keep_mask;
    logic [OFF_W-1:0]     lead_off;
    logic [WORD_BITS-1:0] lead_rest;
    lead_stat_t           lead_stat;
    logic                 out_space;
    logic                 out_load;
    result_t              out_result;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // configuration registers and the range span
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pos_reg <= '0;
            end_pos_reg   <= '0;
            span_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready && cfg_index == REG_START_POS)
            begin
                start_pos_reg <= cfg_data;
            end
            if (cfg_valid && cfg_ready && cfg_index == REG_END_POS)
            begin
                end_pos_reg <= cfg_data;
            end
            span_reg <= end_pos_reg - start_pos_reg;
        end
    end

    // shared leading-one unit
    bpl_lead #(
        .WORD_BITS(WORD_BITS)
    ) u_lead (
        .word   (word_reg),
        .offset (lead_off),
        .rest   (lead_rest),
        .stat   (lead_stat)
    );

    // range check: final word when (index + 1) * WORD_BITS passes the span
    assign span_ext = BASE_W'(span_reg);
    assign base_top = base_reg + BASE_W'(WORD_BITS);

    // keep only offsets up to the span in the final word, none when the word
    // starts beyond the span
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            keep_mask[b] = !past_reg && (OFF_W'(WORD_BITS - 1 - b) <= diff_reg);
        end
    end

    // result of the current scan step
    always_comb
    begin
        out_result.position     = wpos_reg + POS_W'(lead_off);
        out_result.last_in_word = lead_stat.last;
        out_result.range_done   = lead_stat.last && final_reg;
    end

    assign out_load = (state_reg == ST_SCAN) && lead_stat.any && out_space;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        base_next     = base_reg;
        finished_next = finished_reg;
        final_next    = final_reg;
        word_next     = word_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    word_next = WORD_BITS'(bitmap_word);
                    if (first_word)
                    begin
                        count_next    = '0;
                        base_next     = '0;
                        finished_next = 1'b0;
                    end
                    if (first_word || !finished_reg)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                final_next = (base_top > span_ext);
                state_next = ST_MASK;
            end
            ST_MASK:
            begin
                if (final_reg)
                begin
                    word_next     = word_reg & keep_mask;
                    finished_next = 1'b1;
                end
                else if (count_reg == COUNT_MAX)
                begin
                    finished_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    base_next  = base_top;
                end
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (!lead_stat.any)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_space)
                begin
                    word_next = lead_rest;
                    if (lead_stat.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            base_reg     <= '0;
            finished_reg <= 1'b0;
            final_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            base_reg     <= base_next;
            finished_reg <= finished_next;
            final_reg    <= final_next;
        end
    end

    // word, in-word limit and word start position
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (state_reg == ST_CHECK)
        begin
            diff_reg <= OFF_W'(span_ext - base_reg);
            past_reg <= (base_reg > span_ext);
            wpos_reg <= start_pos_reg + POS_W'(base_reg);
        end
    end

    // output register
    bpl_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (out_load),
        .result       (out_result),
        .space        (out_space),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .position     (position),
        .last_in_word (last_in_word),
        .range_done   (range_done)
    );

    // range_done only rides on the last position of a word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_done |-> last_in_word)
        else $error("range_done without last_in_word");

    // a word after the range without restart is dropped at once
    assert property (@(posedge clk) disable iff (!rst_n)
        in_take && finished_reg && !first_word |=> state_reg == ST_IDLE)
        else $error("word past the range was scanned");

    // base tracks the word counter
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK |-> base_reg == BASE_W'(count_reg) * BASE_W'(WORD_BITS))
        else $error("base out of step with word counter");

    // a word that starts beyond the span is always the final one
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MASK && base_reg > span_ext |-> final_reg)
        else $error("word past the span not treated as final");

endmodule

>>> dv/testbench.sv
// testbench: self-checking bench for bitmap_to_position_list
// depends on bpl_pkg and the bitmap_to_position_list rtl; predicts every position in-line
`timescale 1ns / 1ps

module testbench;

    import bpl_pkg::*;

    localparam int WB            = 32;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_PRINTS    = 40;
    localparam int RANDOM_WORDS  = 380;
    // worst case is far below this: every word full, every position stalled for sink_stall_max
    localparam longint TIMEOUT_NS = 64'd4_000_000;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // block ports, all driven to known values from time zero
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [31:0]          bitmap_word = '0;
    logic                 first_word  = 1'b0;
    logic                 out_valid;
    logic                 out_stall   = 1'b1;
    logic [31:0]          position;
    logic                 last_in_word;
    logic                 range_done;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [31:0]          cfg_data    = '0;

    // predictor state, mirrors the block's registers and word counter
    logic [31:0]      pr_start_pos = '0;
    logic [31:0]      pr_end_pos   = '0;
    logic [CNT_W-1:0] pr_word_count = '0;
    logic             pr_finished  = 1'b0;
    int               words_taken  = 0;

    // positions still owed by the block, oldest first
    result_t pending_positions[$];
    result_t seen_pos;
    result_t owed_pos;
    int      mismatch_count = 0;

    // idle control for both sides
    int src_gap_max    = 14;
    int sink_stall_max = 14;
    int sink_wait      = 0;
    int sink_hold      = 0;

    bitmap_to_position_list #(
        .WORD_BITS (WB)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .bitmap_word  (bitmap_word),
        .first_word   (first_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .position     (position),
        .last_in_word (last_in_word),
        .range_done   (range_done),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // free-running clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // one line per mismatch, printing capped
    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("%0t ns: %s expected %h got %h", $time, what, want, got);
    endtask

    // compute the positions one word yields and advance the word counter
    function automatic void predict_word_positions(input logic [31:0] word, input logic fw);
        logic [63:0] span;
        logic [63:0] base;
        logic [63:0] rel;
        logic        final_w;
        logic        have;
        result_t     pend;
        span = {32'd0, pr_end_pos - pr_start_pos};
        have = 1'b0;
        pend = '0;
        if (fw)
        begin
            pr_word_count = '0;
            pr_finished   = 1'b0;
        end
        if (pr_finished)
            return;
        words_taken++;
        final_w = ({36'd0, pr_word_count} >= span / WB);
        base    = {36'd0, pr_word_count} * WB;
        // scan from the msb, which is offset 0
        for (int b = WB - 1; b >= 0; b--)
        begin
            if (word[b])
            begin
                rel = base + 64'(WB - 1 - b);
                if (rel > span)
                    break;
                if (have)
                    pending_positions.push_back(pend);
                pend.position     = pr_start_pos + rel[31:0];
                pend.last_in_word = 1'b0;
                pend.range_done   = 1'b0;
                have = 1'b1;
            end
        end
        if (have)
        begin
            pend.last_in_word = 1'b1;
            pend.range_done   = final_w;
            pending_positions.push_back(pend);
        end
        // counter update
        if (final_w)
            pr_finished = 1'b1;
        else if (pr_word_count == COUNT_MAX)
            pr_finished = 1'b1;
        else
            pr_word_count = pr_word_count + CNT_W'(1);
    endfunction

    // offer one word after a random gap and predict it once accepted
    task automatic send_word(input logic [31:0] word, input logic fw);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        bitmap_word <= word;
        first_word  <= fw;
        do @(posedge clk); while (in_stall !== 1'b0);
        predict_word_positions(word, fw);
    endtask

    // drop valid and wait until every owed position has arrived
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_positions.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, only called while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (idx)
            REG_START_POS: pr_start_pos = val;
            REG_END_POS:   pr_end_pos   = val;
            default:       ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_range(input logic [31:0] lo, input logic [31:0] hi);
        write_reg(REG_START_POS, lo);
        write_reg(REG_END_POS, hi);
    endtask

    // bitmap words of mixed density
    function automatic logic [31:0] random_bitmap();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            3:       return 32'd1 << $urandom_range(0, 31);
            4:       return $urandom & $urandom & $urandom;
            default: return $urandom & $urandom;
        endcase
    endfunction

    // sink side stall, driven at the falling edge
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                out_stall <= 1'b1;
                sink_hold--;
            end
            else if (sink_wait > 0)
            begin
                out_stall <= 1'b1;
                sink_wait--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // compare each position transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            seen_pos.position     = position;
            seen_pos.last_in_word = last_in_word;
            seen_pos.range_done   = range_done;
            if (pending_positions.size() == 0)
                report_mismatch("unexpected position", '0, seen_pos.position);
            else
            begin
                owed_pos = pending_positions.pop_front();
                if (seen_pos.position !== owed_pos.position)
                    report_mismatch("position", owed_pos.position, seen_pos.position);
                if (seen_pos.last_in_word !== owed_pos.last_in_word)
                    report_mismatch("last_in_word", {31'd0, owed_pos.last_in_word},
                                    {31'd0, seen_pos.last_in_word});
                if (seen_pos.range_done !== owed_pos.range_done)
                    report_mismatch("range_done", {31'd0, owed_pos.range_done},
                                    {31'd0, seen_pos.range_done});
            end
            sink_wait = $urandom_range(0, sink_stall_max);
        end
    end

    // reset registers give a one-position range at zero
    task automatic test_reset_values();
        send_word(32'h8000_0000, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0);
        drain_results();
    endtask

    // widest range, full and empty words, unused register indexes
    task automatic test_full_range();
        set_range(32'h0000_0000, 32'hFFFF_FFFF);
        for (int i = REG_END_POS + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), $urandom);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'h8000_0001, 1'b0);
        drain_results();
        // start at the top of the space, positions wrap through zero
        set_range(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_word(32'h8000_0001, 1'b1);
        drain_results();
    endtask

    // end below start, two words in range, then a word past the range
    task automatic test_wrapped_range();
        set_range(32'hFFFF_FFF0, 32'h0000_002F);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'hAAAA_AAAA, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        drain_results();
    endtask

    // bits beyond end_pos are dropped, including a final word left empty
    task automatic test_clipped_end();
        set_range(32'd100, 32'd140);
        send_word(32'h0000_0001, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        send_word(32'h0000_FFFF, 1'b0);
        drain_results();
    endtask

    // empty final word finishes the range silently
    task automatic test_empty_final_word();
        set_range(32'd5, 32'd5);
        send_word(32'h0000_0000, 1'b1);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h8000_0000, 1'b1);
        drain_results();
    endtask

    // first_word in the middle of a range restarts the counter
    task automatic test_restart();
        set_range(32'd0, 32'd1000);
        send_word(32'h0000_0001, 1'b1);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'h0000_0001, 1'b1);
        drain_results();
    endtask

    // sink holds off while full words keep coming, then the source pauses
    task automatic test_backpressure();
        set_range(32'h0000_1000, 32'h0000_1000 + 32'd32 * 32'd40);
        src_gap_max = 0;
        sink_hold   = 300;
        send_word(32'hFFFF_FFFF, 1'b1);
        repeat (11) send_word(32'hFFFF_FFFF, 1'b0);
        drain_results();
        // counter carries on across the pause
        src_gap_max = 14;
        repeat (4) send_word(random_bitmap(), 1'b0);
        drain_results();
    endtask

    // random ranges with well-formed word sequences and some broken ones
    task automatic test_random_sequences(input int target);
        int          goal;
        int          last_w;
        int          len;
        logic        fw;
        logic [31:0] lo;
        logic [31:0] span;
        goal = words_taken + target;
        while (words_taken < goal)
        begin
            drain_results();
            case ($urandom_range(0, 3))
                0:       lo = 32'hFFFF_FFFF - $urandom_range(0, 200);
                1:       lo = $urandom_range(0, 100);
                default: lo = $urandom;
            endcase
            case ($urandom_range(0, 9))
                0:       span = $urandom;
                1:       span = '0;
                default: span = $urandom_range(0, 320);
            endcase
            if ($urandom_range(0, 1))
                set_range(lo, lo + span);
            else
            begin
                write_reg(REG_END_POS, lo + span);
                write_reg(REG_START_POS, lo);
            end
            case ($urandom_range(0, 2))
                0:       src_gap_max = 0;
                1:       src_gap_max = 3;
                default: src_gap_max = 14;
            endcase
            case ($urandom_range(0, 2))
                0:       sink_stall_max = 0;
                1:       sink_stall_max = 3;
                default: sink_stall_max = 14;
            endcase
            repeat ($urandom_range(1, 4))
            begin
                last_w = int'(span / WB);
                len = (last_w > 10 ? 10 : last_w) + $urandom_range(0, 2);
                for (int i = 0; i <= len; i++)
                begin
                    fw = (i == 0);
                    // occasional broken sequence
                    if ($urandom_range(0, 15) == 0)
                        fw = ~fw;
                    send_word(random_bitmap(), fw);
                end
            end
        end
    endtask

    // test sequence
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_reset_values();
        test_full_range();
        test_wrapped_range();
        test_clipped_end();
        test_empty_final_word();
        test_restart();
        test_backpressure();
        test_random_sequences(RANDOM_WORDS);
        drain_results();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/bpl_pkg.sv
rtl/core/bpl_lead.sv
rtl/core/bpl_out.sv
rtl/core/bitmap_to_position_list.sv
dv/testbench.sv
